// File: design/rsm_pkg.sv
// ----------------------------------------------------------------------------
// rsm_pkg: shared types and constants of the ring slot manager
// Holds the operation codes, field widths and the request and result types.
// ----------------------------------------------------------------------------
package rsm_pkg;

    localparam int DEPTH_DEFAULT = 16;
    localparam int KIND_W        = 2;
    localparam int SLOT_W        = 4;
    localparam int COUNT_W       = 5;
    localparam int COUNT_MAX     = 31;

    localparam logic [COUNT_W-1:0] SLOT_COUNT_RESET = 5'd16;

    typedef enum logic [KIND_W-1:0] {
        KIND_PUSH  = 2'd0,
        KIND_POP   = 2'd1,
        KIND_CLEAR = 2'd2
    } kind_t;

    typedef struct packed {
        logic  valid;
        kind_t kind;
        logic  overwritable;
    } op_t;

    typedef struct packed {
        logic              ok;
        logic [SLOT_W-1:0] slot;
        logic              empty_res;
        logic              full_res;
    } result_t;

endpackage

// File: design/ring_slot_manager_overwrite.sv
// ----------------------------------------------------------------------------
// ring_slot_manager_overwrite: slot index manager for a circular buffer
// Grants write slots and releases read slots of a ring, with overwrite of
// unprotected slots when the ring is full.
// ----------------------------------------------------------------------------
// Usage:
// Operations arrive on the slave stream: tuser carries the kind (push, pop,
// clear) and tdata bit 0 the overwritable flag of a push. Each transfer gives
// exactly one result transfer on the master stream with ok, slot, empty and
// full. The slot count register is written through cfg_wen and cfg_wdata;
// the user must write it only while the block is idle; the block does not
// enforce this. Values of zero act as one and values above DEPTH as DEPTH.
// An operation is taken into an input register and executed against the
// pointer, count and mark state, and its result is loaded into the output
// register: one operation per cycle is sustained while results are taken.
// When the receiver stalls, the output register holds its result and the
// input register keeps one more operation, after which s_tready drops.
// Reset empties the ring, clears every protect mark and sets the slot count
// to 16; no clearing pass follows, so operations are taken at once.
// ----------------------------------------------------------------------------
module ring_slot_manager_overwrite #(
    parameter int DEPTH = rsm_pkg::DEPTH_DEFAULT
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_wen,
    input  logic [rsm_pkg::COUNT_W-1:0]      cfg_wdata,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    input  logic [7:0]                       s_tdata,   // overwritable[0], zero fill
    input  logic [rsm_pkg::KIND_W-1:0]       s_tuser,   // kind[1:0]
    output logic                             m_tvalid,
    input  logic                             m_tready,
    output logic [7:0]                       m_tdata    // ok, slot[3:0], empty_res, full_res
);

    logic [rsm_pkg::COUNT_W-1:0] slot_count_reg;
    logic                        in_valid_reg;
    rsm_pkg::kind_t              in_kind_reg;
    logic                        in_ovw_reg;
    logic                        out_valid_reg;
    rsm_pkg::result_t            out_data_reg;

    logic                        advance;
    rsm_pkg::op_t                op;
    rsm_pkg::result_t            result;

    assign advance  = !out_valid_reg || m_tready;
    assign s_tready = !in_valid_reg || advance;

    assign op.valid        = in_valid_reg && advance;
    assign op.kind         = in_kind_reg;
    assign op.overwritable = in_ovw_reg;

    rsm_core #(
        .DEPTH (DEPTH)
    ) u_core (
        .clk        (clk),
        .rst_n      (rst_n),
        .op         (op),
        .slot_count (slot_count_reg),
        .result     (result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slot_count_reg <= rsm_pkg::SLOT_COUNT_RESET;
        end
        else if (cfg_wen)
        begin
            slot_count_reg <= cfg_wdata;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_tready)
        begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            in_kind_reg <= rsm_pkg::kind_t'(s_tuser);
            in_ovw_reg  <= s_tdata[0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (op.valid)
        begin
            out_data_reg <= result;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {1'b0, out_data_reg.full_res, out_data_reg.empty_res,
                       out_data_reg.slot, out_data_reg.ok};

endmodule

// File: design/rsm_core.sv
// ----------------------------------------------------------------------------
// rsm_core: pointer, count and protect mark state of the ring
// Executes one operation per cycle and returns its result combinationally.
// ----------------------------------------------------------------------------
module rsm_core #(
    parameter int DEPTH = rsm_pkg::DEPTH_DEFAULT
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  rsm_pkg::op_t                      op,
    input  logic [rsm_pkg::COUNT_W-1:0]       slot_count,
    output rsm_pkg::result_t                  result
);

    // Slot numbers never reach past the widest slot count, so marks above it are never used.
    localparam int MARKS = (DEPTH < rsm_pkg::COUNT_MAX) ? DEPTH : rsm_pkg::COUNT_MAX;
    localparam int PW    = $clog2(MARKS);
    localparam logic [rsm_pkg::COUNT_W-1:0] MAX_N = rsm_pkg::COUNT_W'(MARKS);

    logic [PW-1:0]                wp_reg, wp_next;
    logic [PW-1:0]                rp_reg, rp_next;
    logic [rsm_pkg::COUNT_W-1:0]  fill_reg, fill_next;
    logic [MARKS-1:0]             marks_reg, marks_next;

    logic [rsm_pkg::COUNT_W-1:0]  n;
    logic [PW-1:0]                wp_adv, rp_adv;
    logic                         wp_in, rp_in;
    logic                         ok;
    logic [PW-1:0]                slot_v;

    always_comb
    begin
        if (slot_count == '0)
        begin
            n = rsm_pkg::COUNT_W'(1);
        end
        else if (slot_count > MAX_N)
        begin
            n = MAX_N;
        end
        else
        begin
            n = slot_count;
        end

        wp_adv = (rsm_pkg::COUNT_W'(wp_reg) >= n - rsm_pkg::COUNT_W'(1)) ? '0 : wp_reg + PW'(1);
        rp_adv = (rsm_pkg::COUNT_W'(rp_reg) >= n - rsm_pkg::COUNT_W'(1)) ? '0 : rp_reg + PW'(1);
        wp_in  = rsm_pkg::COUNT_W'(wp_reg) < n;
        rp_in  = rsm_pkg::COUNT_W'(rp_reg) < n;

        wp_next    = wp_reg;
        rp_next    = rp_reg;
        fill_next  = fill_reg;
        marks_next = marks_reg;
        ok         = 1'b0;
        slot_v     = '0;

        case (op.kind)
            rsm_pkg::KIND_PUSH:
            begin
                if (fill_reg < n)
                begin
                    wp_next = wp_adv;
                    if (wp_in)
                    begin
                        marks_next[wp_reg] = ~op.overwritable;
                    end
                    fill_next = fill_reg + rsm_pkg::COUNT_W'(1);
                    ok        = 1'b1;
                    slot_v    = wp_reg;
                end
                else if (wp_in && !marks_reg[wp_reg])
                begin
                    // The ring is full: the oldest slot is given up to the new transfer.
                    wp_next            = wp_adv;
                    rp_next            = rp_adv;
                    marks_next[wp_reg] = ~op.overwritable;
                    ok                 = 1'b1;
                    slot_v             = wp_reg;
                end
            end
            rsm_pkg::KIND_POP:
            begin
                if (fill_reg != '0)
                begin
                    rp_next = rp_adv;
                    if (rp_in)
                    begin
                        marks_next[rp_reg] = 1'b0;
                    end
                    fill_next = fill_reg - rsm_pkg::COUNT_W'(1);
                    ok        = 1'b1;
                    slot_v    = rp_reg;
                end
            end
            rsm_pkg::KIND_CLEAR:
            begin
                wp_next    = '0;
                rp_next    = '0;
                fill_next  = '0;
                marks_next = '0;
                ok         = 1'b1;
            end
            default:
            begin
            end
        endcase

        result.ok        = ok;
        result.slot      = rsm_pkg::SLOT_W'(slot_v);
        result.empty_res = (fill_next == '0);
        result.full_res  = (fill_next >= n);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg    <= '0;
            rp_reg    <= '0;
            fill_reg  <= '0;
            marks_reg <= '0;
        end
        else if (op.valid)
        begin
            wp_reg    <= wp_next;
            rp_reg    <= rp_next;
            fill_reg  <= fill_next;
            marks_reg <= marks_next;
        end
    end

    a_fill_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg <= MAX_N)
        else $error("fill count exceeds the largest slot count");

    a_clear_empties: assert property (@(posedge clk) disable iff (!rst_n)
        op.valid && op.kind == rsm_pkg::KIND_CLEAR |=>
        fill_reg == '0 && wp_reg == '0 && rp_reg == '0 && marks_reg == '0)
        else $error("clear did not empty the ring");

    a_pop_empty_refused: assert property (@(posedge clk) disable iff (!rst_n)
        op.valid && op.kind == rsm_pkg::KIND_POP && fill_reg == '0 |-> !result.ok)
        else $error("pop from an empty ring was granted");

    a_push_counts: assert property (@(posedge clk) disable iff (!rst_n)
        op.valid && op.kind == rsm_pkg::KIND_PUSH && fill_reg < n |=>
        fill_reg == $past(fill_reg) + rsm_pkg::COUNT_W'(1))
        else $error("push into a ring with room did not raise the count");

endmodule

// File: tb/ring_slot_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ring_slot_checker: result checker for the ring slot manager
// Watches the register port and both streams, keeps its own copy of the
// pointers, fill count, protect marks and slot count, works out the result of
// every accepted operation and compares each result transfer with the oldest
// one still due.
// ----------------------------------------------------------------------------
module ring_slot_checker #(
    parameter int DEPTH = rsm_pkg::DEPTH_DEFAULT
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cfg_wen,
    input  logic [rsm_pkg::COUNT_W-1:0] cfg_wdata,
    input  logic                        s_tvalid,
    input  logic                        s_tready,
    input  logic [7:0]                  s_tdata,   // overwritable[0], zero fill
    input  logic [rsm_pkg::KIND_W-1:0]  s_tuser,   // kind[1:0]
    input  logic                        m_tvalid,
    input  logic                        m_tready,
    input  logic [7:0]                  m_tdata,   // ok, slot[3:0], empty_res, full_res
    output int                          errors,
    output int                          outstanding,
    output int                          checked,
    output int                          overwrites,
    output int                          refusals
);

    logic [rsm_pkg::SLOT_W-1:0]  wr_ptr;
    logic [rsm_pkg::SLOT_W-1:0]  rd_ptr;
    logic [rsm_pkg::COUNT_W-1:0] fill;
    logic [rsm_pkg::COUNT_W-1:0] slot_cfg;
    logic                        protect_mark [DEPTH];
    rsm_pkg::result_t            due_reports [$];

    function automatic logic [rsm_pkg::SLOT_W-1:0] next_slot(
        input logic [rsm_pkg::SLOT_W-1:0] p, input int n);
        return (int'(p) >= n - 1) ? '0 : p + 1'b1;
    endfunction

    function automatic void empty_ring();
        wr_ptr = '0;
        rd_ptr = '0;
        fill   = '0;
        for (int i = 0; i < DEPTH; i++)
        begin
            protect_mark[i] = 1'b0;
        end
    endfunction

    // Applies one operation to the ring copy and returns the report it gives.
    function automatic rsm_pkg::result_t slot_report(input logic [rsm_pkg::KIND_W-1:0] k,
                                                     input logic ovw);
        rsm_pkg::result_t           r;
        int                         n;
        logic [rsm_pkg::SLOT_W-1:0] cur;
        r = '0;
        n = (slot_cfg == '0) ? 1 : ((int'(slot_cfg) > DEPTH) ? DEPTH : int'(slot_cfg));
        case (k)
            rsm_pkg::KIND_PUSH:
            begin
                cur = wr_ptr;
                if (int'(fill) < n)
                begin
                    wr_ptr = next_slot(cur, n);
                    if (int'(cur) < n)
                        protect_mark[cur] = !ovw;
                    fill   = fill + 1'b1;
                    r.ok   = 1'b1;
                    r.slot = cur;
                end
                else if (int'(cur) < n && !protect_mark[cur])
                begin
                    wr_ptr = next_slot(cur, n);
                    rd_ptr = next_slot(rd_ptr, n);
                    protect_mark[cur] = !ovw;
                    r.ok   = 1'b1;
                    r.slot = cur;
                    overwrites++;
                end
            end
            rsm_pkg::KIND_POP:
            begin
                cur = rd_ptr;
                if (fill != '0)
                begin
                    rd_ptr = next_slot(cur, n);
                    if (int'(cur) < n)
                        protect_mark[cur] = 1'b0;
                    fill   = fill - 1'b1;
                    r.ok   = 1'b1;
                    r.slot = cur;
                end
            end
            rsm_pkg::KIND_CLEAR:
            begin
                empty_ring();
                r.ok = 1'b1;
            end
            default:
            begin
            end
        endcase
        if (!r.ok)
            refusals++;
        r.empty_res = (fill == '0);
        r.full_res  = (int'(fill) >= n);
        return r;
    endfunction

    task automatic log_failure(input string what, input rsm_pkg::result_t want,
                               input rsm_pkg::result_t seen);
        errors++;
        if (errors <= 10)
            $display("%0t %s: want ok/slot/empty/full %0b/%0d/%0b/%0b, got %0b/%0d/%0b/%0b",
                     $realtime, what, want.ok, want.slot, want.empty_res, want.full_res,
                     seen.ok, seen.slot, seen.empty_res, seen.full_res);
    endtask

    initial
    begin
        errors      = 0;
        outstanding = 0;
        checked     = 0;
        overwrites  = 0;
        refusals    = 0;
    end

    always @(posedge clk or negedge rst_n)
    begin : watch
        rsm_pkg::result_t seen;
        rsm_pkg::result_t want;
        if (!rst_n)
        begin
            slot_cfg = rsm_pkg::SLOT_COUNT_RESET;
            empty_ring();
            due_reports.delete();
            outstanding = 0;
        end
        else
        begin
            if (cfg_wen)
                slot_cfg = cfg_wdata;
            if (m_tvalid && m_tready)
            begin
                seen.ok        = m_tdata[0];
                seen.slot      = m_tdata[4:1];
                seen.empty_res = m_tdata[5];
                seen.full_res  = m_tdata[6];
                checked++;
                if (due_reports.size() == 0)
                begin
                    log_failure("result transfer with none due", '0, seen);
                end
                else
                begin
                    want = due_reports.pop_front();
                    if (seen.ok !== want.ok || seen.slot !== want.slot ||
                        seen.empty_res !== want.empty_res || seen.full_res !== want.full_res)
                        log_failure("result mismatch", want, seen);
                end
            end
            if (s_tvalid && s_tready)
                due_reports.push_back(slot_report(s_tuser, s_tdata[0]));
            outstanding = due_reports.size();
        end
    end

endmodule

// File: tb/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: testbench top of the ring slot manager
// Drives directed and random push, pop and clear operations under several
// slot counts, with random idle bursts on both streams, a long result stall
// and full drains. The checker beside the block predicts and compares every
// result; this module gives the verdict.
// ----------------------------------------------------------------------------
module tb;

    localparam logic [rsm_pkg::KIND_W-1:0] KIND_UNUSED = 2'd3;
    localparam int HOLD_CYCLES  = 60;
    localparam int QUIET_LIMIT  = 1000;
    localparam int PHASES       = 10;
    localparam int PHASE_ITEMS  = 80;

    logic                         clk        = 1'b0;
    logic                         rst_n      = 1'b0;
    logic                         cfg_wen    = 1'b0;
    logic [rsm_pkg::COUNT_W-1:0]  cfg_wdata  = '0;
    logic                         s_tvalid   = 1'b0;
    logic                         s_tready;
    logic [7:0]                   s_tdata    = '0;
    logic [rsm_pkg::KIND_W-1:0]   s_tuser    = '0;
    logic                         m_tvalid;
    logic                         m_tready   = 1'b0;
    logic [7:0]                   m_tdata;

    int errors;
    int outstanding;
    int checked;
    int overwrites;
    int refusals;
    int items       = 0;
    int settings    = 0;
    bit idle_on     = 1'b1;
    bit hold_results = 1'b0;

    ring_slot_manager_overwrite uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wen   (cfg_wen),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    ring_slot_checker u_checker (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wen     (cfg_wen),
        .cfg_wdata   (cfg_wdata),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .errors      (errors),
        .outstanding (outstanding),
        .checked     (checked),
        .overwrites  (overwrites),
        .refusals    (refusals)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    task automatic send_op(input logic [rsm_pkg::KIND_W-1:0] k, input logic ovw);
        s_tvalid <= 1'b1;
        s_tuser  <= k;
        s_tdata  <= {7'b0, ovw};
        do
            @(posedge clk);
        while (!s_tready);
        items++;
        if (idle_on && $urandom_range(0, 6) == 0)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 9)) @(posedge clk);
        end
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        do
            @(posedge clk);
        while (outstanding != 0);
    endtask

    task automatic set_slot_count(input logic [rsm_pkg::COUNT_W-1:0] value);
        drain();
        cfg_wen   <= 1'b1;
        cfg_wdata <= value;
        @(posedge clk);
        cfg_wen   <= 1'b0;
        settings++;
    endtask

    task automatic random_op(input int push_pct, input int ovw_pct);
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 3)
            send_op(rsm_pkg::KIND_CLEAR, 1'($urandom_range(0, 1)));
        else if (pick < 5)
            send_op(KIND_UNUSED, 1'($urandom_range(0, 1)));
        else if (pick < 5 + push_pct)
            send_op(rsm_pkg::KIND_PUSH, $urandom_range(0, 99) < ovw_pct);
        else
            send_op(rsm_pkg::KIND_POP, 1'($urandom_range(0, 1)));
    endtask

    initial
    begin : result_sink
        wait (rst_n === 1'b1);
        forever
        begin
            if (hold_results)
            begin
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_results = 1'b0;
            end
            else if (idle_on && $urandom_range(0, 4) == 0)
            begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 9)) @(posedge clk);
            end
            m_tready <= 1'b1;
            repeat ($urandom_range(1, 10)) @(posedge clk);
        end
    end

    initial
    begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < QUIET_LIMIT)
        begin
            @(posedge clk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                quiet = 0;
            else
                quiet++;
        end
        $display("== FAIL ==");
        $finish;
    end

    initial
    begin : stimulus
        logic [rsm_pkg::COUNT_W-1:0] cfg_plan  [PHASES];
        int                          push_plan [PHASES];
        int                          ovw_plan  [PHASES];
        cfg_plan  = '{5'd16, 5'd1, 5'd3, 5'd0, 5'd31, 5'd2, 5'd17, 5'd8, 5'd16, 5'd4};
        push_plan = '{55, 60, 70, 50, 65, 75, 60, 45, 80, 55};
        ovw_plan  = '{50, 80, 30, 90, 60, 20, 70, 50, 85, 40};
        cfg_plan[7] = rsm_pkg::COUNT_W'($urandom_range(1, 16));

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Refusals on an empty ring, the unused kind and a clear at reset size.
        send_op(rsm_pkg::KIND_POP, 1'b0);
        send_op(KIND_UNUSED, 1'b1);
        send_op(rsm_pkg::KIND_CLEAR, 1'b0);
        send_op(rsm_pkg::KIND_PUSH, 1'b0);
        send_op(rsm_pkg::KIND_POP, 1'b1);

        // Small ring: fill, overwrite an open slot, refuse a protected one.
        set_slot_count(5'd3);
        send_op(rsm_pkg::KIND_PUSH, 1'b1);
        send_op(rsm_pkg::KIND_PUSH, 1'b0);
        send_op(rsm_pkg::KIND_PUSH, 1'b1);
        send_op(rsm_pkg::KIND_PUSH, 1'b1);
        send_op(rsm_pkg::KIND_PUSH, 1'b1);
        send_op(rsm_pkg::KIND_POP, 1'b0);
        send_op(rsm_pkg::KIND_PUSH, 1'b0);
        send_op(rsm_pkg::KIND_POP, 1'b0);
        send_op(rsm_pkg::KIND_POP, 1'b0);
        send_op(rsm_pkg::KIND_POP, 1'b0);
        send_op(rsm_pkg::KIND_POP, 1'b0);

        // Single slot ring, with overwrite and then a protected slot.
        set_slot_count(5'd1);
        send_op(rsm_pkg::KIND_PUSH, 1'b1);
        send_op(rsm_pkg::KIND_PUSH, 1'b0);
        send_op(rsm_pkg::KIND_PUSH, 1'b1);
        send_op(rsm_pkg::KIND_POP, 1'b0);
        send_op(rsm_pkg::KIND_CLEAR, 1'b1);

        // Random phases; the ring is not emptied between them, so slots left
        // beyond a shrunk slot count are exercised too.
        for (int p = 0; p < PHASES; p++)
        begin
            idle_on = (p != 3) && (p != PHASES - 1);
            set_slot_count(cfg_plan[p]);
            for (int i = 0; i < PHASE_ITEMS; i++)
            begin
                if (p == 2 && i == PHASE_ITEMS / 2)
                    drain();
                if (p == 4 && i == PHASE_ITEMS / 2)
                begin
                    hold_results = 1'b1;
                    wait (m_tready === 1'b0);
                    repeat (12) send_op(rsm_pkg::KIND_PUSH, 1'($urandom_range(0, 1)));
                end
                random_op(push_plan[p], ovw_plan[p]);
            end
        end

        drain();
        repeat (8) @(posedge clk);
        $display("Ran %0d operations under %0d slot-count settings; %0d results checked.",
                 items, settings, checked);
        $display("Overwrites granted: %0d, operations refused: %0d.", overwrites, refusals);
        if (errors == 0 && outstanding == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
